// File: rtl/core/vector2d_length_and_unit_assert.svh
// Assertion macros for the vector length and unit block.
`ifndef VECTOR2D_LENGTH_AND_UNIT_ASSERT_SVH
`define VECTOR2D_LENGTH_AND_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define V2LU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The condition must hold at every clock edge out of reset.
`define V2LU_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

`endif

// File: rtl/core/v2lu_pkg.sv
`default_nettype none

package v2lu_pkg;

  // Control bits that travel with every item through the pipeline.
  typedef struct packed {
    logic valid;
    logic zero;
    logic neg_x;
    logic neg_y;
  } ctl_t;

endpackage

`default_nettype wire

// File: rtl/core/v2lu_stage.sv
`default_nettype none

module v2lu_stage #(
  parameter int CoordWidth = 16,
  parameter int UnitFraction = 14,
  parameter int K = 0
) (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire v2lu_pkg::ctl_t                      ctl_i,
  input  wire [2*CoordWidth-1:0]                   s_i,
  input  wire [CoordWidth-1:0]                     root_i,
  input  wire [CoordWidth+1:0]                     rem_i,
  input  wire [2*CoordWidth+2*UnitFraction+1:0]    rx_i,
  input  wire [2*CoordWidth+2*UnitFraction+1:0]    qsx_i,
  input  wire [UnitFraction:0]                     qx_i,
  input  wire [2*CoordWidth+2*UnitFraction+1:0]    ry_i,
  input  wire [2*CoordWidth+2*UnitFraction+1:0]    qsy_i,
  input  wire [UnitFraction:0]                     qy_i,
  output v2lu_pkg::ctl_t                           ctl_o,
  output logic [2*CoordWidth-1:0]                  s_o,
  output logic [CoordWidth-1:0]                    root_o,
  output logic [CoordWidth+1:0]                    rem_o,
  output logic [2*CoordWidth+2*UnitFraction+1:0]   rx_o,
  output logic [2*CoordWidth+2*UnitFraction+1:0]   qsx_o,
  output logic [UnitFraction:0]                    qx_o,
  output logic [2*CoordWidth+2*UnitFraction+1:0]   ry_o,
  output logic [2*CoordWidth+2*UnitFraction+1:0]   qsy_o,
  output logic [UnitFraction:0]                    qy_o
);
  import v2lu_pkg::*;

  localparam int TW = 2*CoordWidth + 2*UnitFraction + 2;
  localparam bit DoSqrt = (K < CoordWidth);
  localparam bit DoUnit = (K <= UnitFraction);
  localparam int SI = DoSqrt ? (CoordWidth - 1 - K) : 0;
  localparam int B = DoUnit ? (UnitFraction - K) : 0;

  ctl_t ctl_q;
  logic [2*CoordWidth-1:0] s_q;
  logic [CoordWidth-1:0] root_d, root_q;
  logic [CoordWidth+1:0] rem_d, rem_q;
  logic [TW-1:0] rx_d, rx_q, qsx_d, qsx_q, ry_d, ry_q, qsy_d, qsy_q;
  logic [UnitFraction:0] qx_d, qx_q, qy_d, qy_q;

  // One digit of the restoring square root.
  generate
    if (DoSqrt) begin : g_sqrt
      logic [CoordWidth+1:0] shifted, trial;
      always_comb begin
        shifted = {rem_i[CoordWidth-1:0], s_i[2*SI+1 -: 2]};
        trial = {root_i, 2'b01};
        if (shifted >= trial) begin
          rem_d = shifted - trial;
          root_d = {root_i[CoordWidth-2:0], 1'b1};
        end else begin
          rem_d = shifted;
          root_d = {root_i[CoordWidth-2:0], 1'b0};
        end
      end
    end else begin : g_sqrt_pass
      assign rem_d = rem_i;
      assign root_d = root_i;
    end
  endgenerate

  // One quotient bit of each unit component. The remainder holds
  // a^2 * 2^(2F) - q^2 * s and qs holds q * s, so setting bit B costs
  // (q*s << (B+1)) + (s << 2B).
  generate
    if (DoUnit) begin : g_unit
      logic [TW-1:0] s_ext, tx, ty;
      always_comb begin
        s_ext = TW'(s_i);
        tx = (qsx_i << (B + 1)) + (s_ext << (2*B));
        ty = (qsy_i << (B + 1)) + (s_ext << (2*B));
        rx_d = rx_i;
        qsx_d = qsx_i;
        qx_d = qx_i;
        if (rx_i >= tx) begin
          rx_d = rx_i - tx;
          qsx_d = qsx_i + (s_ext << B);
          qx_d[B] = 1'b1;
        end
        ry_d = ry_i;
        qsy_d = qsy_i;
        qy_d = qy_i;
        if (ry_i >= ty) begin
          ry_d = ry_i - ty;
          qsy_d = qsy_i + (s_ext << B);
          qy_d[B] = 1'b1;
        end
      end
    end else begin : g_unit_pass
      assign rx_d = rx_i;
      assign qsx_d = qsx_i;
      assign qx_d = qx_i;
      assign ry_d = ry_i;
      assign qsy_d = qsy_i;
      assign qy_d = qy_i;
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_i;
    root_q <= root_d;
    rem_q <= rem_d;
    rx_q <= rx_d;
    qsx_q <= qsx_d;
    qx_q <= qx_d;
    ry_q <= ry_d;
    qsy_q <= qsy_d;
    qy_q <= qy_d;
  end

  assign ctl_o = ctl_q;
  assign s_o = s_q;
  assign root_o = root_q;
  assign rem_o = rem_q;
  assign rx_o = rx_q;
  assign qsx_o = qsx_q;
  assign qx_o = qx_q;
  assign ry_o = ry_q;
  assign qsy_o = qsy_q;
  assign qy_o = qy_q;

endmodule

`default_nettype wire

// File: rtl/core/vector2d_length_and_unit.sv
// Vector length and unit vector. A new vector may be started in every cycle
// (busy_o never rises). Each transaction passes through the magnitude,
// squaring and sum stages, the bit-per-stage square root and unit-component
// quotient pipeline and an output register; its result is marked by a
// one-cycle done_o. Results come out in the order the vectors went in and
// cannot be held off. A zero vector gives zero_length_o high with length
// and unit components zero.
`default_nettype none

module vector2d_length_and_unit #(
  parameter int COORD_WIDTH = 16,
  parameter int UNIT_FRACTION = 14
) (
  input  wire                         clk_i,
  input  wire                         rst_ni,
  input  wire                         start_i,
  output logic                        busy_o,
  input  wire  [COORD_WIDTH-1:0]      vec_x_i,
  input  wire  [COORD_WIDTH-1:0]      vec_y_i,
  output logic                        done_o,
  output logic [COORD_WIDTH-1:0]      length_o,
  output logic [UNIT_FRACTION+1:0]    unit_x_o,
  output logic [UNIT_FRACTION+1:0]    unit_y_o,
  output logic                        zero_length_o
);
  import v2lu_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int UF = UNIT_FRACTION;
  localparam int TW = 2*CW + 2*UF + 2;
  localparam int NS = (CW > UF + 1) ? CW : (UF + 1);
  localparam int Latency = NS + 4;

  // Magnitude stage.
  ctl_t c1_q;
  logic [CW-1:0] ax_q, ay_q;
  // Squaring stage.
  ctl_t c2_q;
  logic [2*CW-1:0] sqx_q, sqy_q;
  // Sum stage.
  ctl_t c3_d;
  logic [2*CW-1:0] s3_d;

  ctl_t ctl[NS+1];
  logic [2*CW-1:0] s_a[NS+1];
  logic [CW-1:0] root_a[NS+1];
  logic [CW+1:0] rem_a[NS+1];
  logic [TW-1:0] rx_a[NS+1], qsx_a[NS+1], ry_a[NS+1], qsy_a[NS+1];
  logic [UF:0] qx_a[NS+1], qy_a[NS+1];

  ctl_t c3_q;
  logic [2*CW-1:0] s3_q, sq3x_q, sq3y_q;

  logic out_valid_q, out_zero_q;
  logic [CW-1:0] out_len_q;
  logic [UF+1:0] out_ux_q, out_uy_q, ux_d, uy_d;
  ctl_t cin;

  assign busy_o = 1'b0;

  always_comb begin
    cin.valid = start_i;
    cin.zero = 1'b0;
    cin.neg_x = vec_x_i[CW-1];
    cin.neg_y = vec_y_i[CW-1];
  end

  always_comb begin
    c3_d = c2_q;
    s3_d = sqx_q + sqy_q;
    c3_d.zero = (s3_d == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_q <= '0;
      c2_q <= '0;
      c3_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      c1_q <= cin;
      c2_q <= c1_q;
      c3_q <= c3_d;
      out_valid_q <= ctl[NS].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q <= vec_x_i[CW-1] ? (~vec_x_i + 1'b1) : vec_x_i;
    ay_q <= vec_y_i[CW-1] ? (~vec_y_i + 1'b1) : vec_y_i;
    sqx_q <= (2*CW)'(ax_q) * (2*CW)'(ax_q);
    sqy_q <= (2*CW)'(ay_q) * (2*CW)'(ay_q);
    s3_q <= s3_d;
    sq3x_q <= sqx_q;
    sq3y_q <= sqy_q;
  end

  assign ctl[0] = c3_q;
  assign s_a[0] = s3_q;
  assign root_a[0] = '0;
  assign rem_a[0] = '0;
  assign rx_a[0] = TW'(sq3x_q) << (2*UF);
  assign ry_a[0] = TW'(sq3y_q) << (2*UF);
  assign qsx_a[0] = '0;
  assign qsy_a[0] = '0;
  assign qx_a[0] = '0;
  assign qy_a[0] = '0;

  generate
    for (genvar k = 0; k < NS; k++) begin : g_stage
      v2lu_stage #(
        .CoordWidth(CW),
        .UnitFraction(UF),
        .K(k)
      ) u_stage (
        .clk_i (clk_i),
        .rst_ni(rst_ni),
        .ctl_i (ctl[k]),
        .s_i   (s_a[k]),
        .root_i(root_a[k]),
        .rem_i (rem_a[k]),
        .rx_i  (rx_a[k]),
        .qsx_i (qsx_a[k]),
        .qx_i  (qx_a[k]),
        .ry_i  (ry_a[k]),
        .qsy_i (qsy_a[k]),
        .qy_i  (qy_a[k]),
        .ctl_o (ctl[k+1]),
        .s_o   (s_a[k+1]),
        .root_o(root_a[k+1]),
        .rem_o (rem_a[k+1]),
        .rx_o  (rx_a[k+1]),
        .qsx_o (qsx_a[k+1]),
        .qx_o  (qx_a[k+1]),
        .ry_o  (ry_a[k+1]),
        .qsy_o (qsy_a[k+1]),
        .qy_o  (qy_a[k+1])
      );
    end
  endgenerate

  // A zero vector would pass every quotient trial, so its components are forced.
  always_comb begin
    ux_d = ctl[NS].neg_x ? (~{1'b0, qx_a[NS]} + 1'b1) : {1'b0, qx_a[NS]};
    uy_d = ctl[NS].neg_y ? (~{1'b0, qy_a[NS]} + 1'b1) : {1'b0, qy_a[NS]};
    if (ctl[NS].zero) begin
      ux_d = '0;
      uy_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_zero_q <= ctl[NS].zero;
    out_len_q <= root_a[NS];
    out_ux_q <= ux_d;
    out_uy_q <= uy_d;
  end

  assign done_o = out_valid_q;
  assign zero_length_o = out_zero_q;
  assign length_o = out_len_q;
  assign unit_x_o = out_ux_q;
  assign unit_y_o = out_uy_q;

`include "vector2d_length_and_unit_assert.svh"

  `V2LU_ASSERT_ALWAYS(a_never_busy, !busy_o, "busy raised on a non-stalling pipeline")
  `V2LU_ASSERT_IMPL(a_latency, done_o, $past(start_i, Latency), "result without a transaction")
  `V2LU_ASSERT_IMPL(a_zero_out, done_o && zero_length_o,
    (length_o == '0) && (unit_x_o == '0) && (unit_y_o == '0), "zero vector gave non-zero result")
  `V2LU_ASSERT_IMPL(a_len_nonzero, done_o && !zero_length_o, length_o != '0,
    "non-zero vector gave zero length")

endmodule

`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
`default_nettype none

module tb;

  localparam int CW = 16;
  localparam int UF = 14;
  localparam int UW = UF + 2;
  localparam int LATENCY = 20;
  localparam int N_RANDOM = 1700;
  localparam longint CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [CW-1:0] length;
    logic [UW-1:0] unit_x;
    logic [UW-1:0] unit_y;
    logic          zero_length;
  } norm_t;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    bit            typed;
    norm_t         want;
  } row_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start_i = 1'b0;
  logic [CW-1:0] vec_x_i = '0;
  logic [CW-1:0] vec_y_i = '0;
  logic          busy_o;
  logic          done_o;
  logic [CW-1:0] length_o;
  logic [UW-1:0] unit_x_o;
  logic [UW-1:0] unit_y_o;
  logic          zero_length_o;

  norm_t  pending_norms[$];
  int     n_errors = 0;
  int     n_sent = 0;
  int     n_checked = 0;
  int     n_zero = 0;
  longint cycles = 0;
  int     idle_pct = 0;

  vector2d_length_and_unit #(.COORD_WIDTH(CW), .UNIT_FRACTION(UF)) dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o),
    .vec_x_i(vec_x_i), .vec_y_i(vec_y_i), .done_o(done_o),
    .length_o(length_o), .unit_x_o(unit_x_o), .unit_y_o(unit_y_o),
    .zero_length_o(zero_length_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic longint unsigned mag_of(logic [CW-1:0] v);
    longint signed s;
    s = longint'($signed(v));
    return (s < 0) ? -s : s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      if ((r | (64'd1 << b)) * (r | (64'd1 << b)) <= n) r |= 64'd1 << b;
    end
    return r;
  endfunction

  // Largest q with q^2 * s <= a^2 * 2^(2*UF), found bit by bit on wide integers.
  function automatic logic [UW-1:0] unit_part(logic [CW-1:0] v, longint unsigned s);
    longint unsigned a;
    logic [127:0] rhs;
    logic [127:0] lhs;
    longint unsigned q;
    longint unsigned c;
    a = mag_of(v);
    rhs = 128'(a * a) << (2 * UF);
    q = 0;
    for (int b = UF; b >= 0; b--) begin
      c = q | (64'd1 << b);
      lhs = 128'(c * c) * 128'(s);
      if (lhs <= rhs) q = c;
    end
    return v[CW-1] ? UW'(-q) : UW'(q);
  endfunction

  function automatic norm_t normalise(logic [CW-1:0] x, logic [CW-1:0] y);
    norm_t r;
    longint unsigned s;
    s = mag_of(x) * mag_of(x) + mag_of(y) * mag_of(y);
    if (s == 0) begin
      r = '{length: '0, unit_x: '0, unit_y: '0, zero_length: 1'b1};
    end else begin
      r.length = CW'(int_sqrt(s));
      r.unit_x = unit_part(x, s);
      r.unit_y = unit_part(y, s);
      r.zero_length = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    n_errors++;
    $display("mismatch at transaction %0d: %s got %0d expected %0d",
             n_checked, what, got, want);
  endtask

  // Drive one transaction; start stays high between back-to-back items and drops only for idle gaps.
  task automatic send_vector(logic [CW-1:0] x, logic [CW-1:0] y, norm_t want);
    while ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    vec_x_i <= x;
    vec_y_i <= y;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    pending_norms.push_back(want);
    n_sent++;
    if (want.zero_length) n_zero++;
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      norm_t exp_n;
      if (pending_norms.size() == 0) begin
        report_mismatch("unexpected result, count", 1, 0);
      end else begin
        exp_n = pending_norms.pop_front();
        if (length_o !== exp_n.length) report_mismatch("length", length_o, exp_n.length);
        if (unit_x_o !== exp_n.unit_x)
          report_mismatch("unit_x", $signed(unit_x_o), $signed(exp_n.unit_x));
        if (unit_y_o !== exp_n.unit_y)
          report_mismatch("unit_y", $signed(unit_y_o), $signed(exp_n.unit_y));
        if (zero_length_o !== exp_n.zero_length)
          report_mismatch("zero_length", zero_length_o, exp_n.zero_length);
      end
      n_checked++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_norms.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    int pick;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Some extremes, axis cases and the zero vector carry typed-in results; the rest use normalise.
    rows.push_back('{16'h0000, 16'h0000, 1, '{16'd0, 16'd0, 16'd0, 1'b1}});
    rows.push_back('{16'h0100, 16'h0000, 1, '{16'h0100, 16'd16384, 16'd0, 1'b0}});
    rows.push_back('{16'h0000, 16'hff00, 1, '{16'h0100, 16'd0, -16'sd16384, 1'b0}});
    rows.push_back('{16'h8000, 16'h0000, 1, '{16'h8000, -16'sd16384, 16'd0, 1'b0}});
    rows.push_back('{16'h0000, 16'h7fff, 1, '{16'h7fff, 16'd0, 16'd16384, 1'b0}});
    rows.push_back('{16'h0001, 16'h0000, 1, '{16'h0001, 16'd16384, 16'd0, 1'b0}});
    rows.push_back('{16'h8000, 16'h8000, 1, '{16'd46340, -16'sd11585, -16'sd11585, 1'b0}});
    rows.push_back('{16'h7fff, 16'h7fff, 0, '0});
    rows.push_back('{16'h7fff, 16'h8000, 0, '0});
    rows.push_back('{16'h8000, 16'h7fff, 0, '0});
    rows.push_back('{16'h0300, 16'h0400, 0, '0});
    rows.push_back('{16'hfd00, 16'hfc00, 0, '0});
    rows.push_back('{16'h0001, 16'h0001, 0, '0});
    rows.push_back('{16'hffff, 16'h0001, 0, '0});
    rows.push_back('{16'h5555, 16'haaaa, 0, '0});
    rows.push_back('{16'h0001, 16'h7fff, 0, '0});
    foreach (rows[i]) begin
      r = rows[i];
      send_vector(r.x, r.y, r.typed ? r.want : normalise(r.x, r.y));
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      case ((i * 5) / N_RANDOM)
        0: idle_pct = 0;
        1: idle_pct = 52;
        2: idle_pct = 0;
        3: idle_pct = 16;
        default: idle_pct = 52;
      endcase
      pick = $urandom_range(9);
      x = CW'($urandom);
      y = CW'($urandom);
      if (pick == 0) begin
        x = '0;
      end else if (pick == 1) begin
        y = '0;
      end else if (pick == 2) begin
        x = $signed(8'($urandom));
        y = $signed(8'($urandom));
      end else if (pick == 3 && $urandom_range(7) == 0) begin
        x = '0;
        y = '0;
      end
      send_vector(x, y, normalise(x, y));
    end
    start_i <= 1'b0;

    while (pending_norms.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 5) @(posedge clk_i);
    $display("Sent %0d vectors (%0d zero), checked %0d results under varied start gaps.",
             n_sent, n_zero, n_checked);
    if (n_errors == 0 && pending_norms.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
